// ----- rtl/utf8_decode_with_column_width_assert.svh -----
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared concurrent assertion forms for the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_DECODE_WITH_COLUMN_WIDTH_ASSERT_SVH
`define UTF8_DECODE_WITH_COLUMN_WIDTH_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define UCW_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define UCW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/utf8cw_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Shared types, constants and the column width lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8cw_pkg;

   localparam int SUM_BITS   = 16;
   localparam int PEND_DEPTH = 4;

   // Depth of the byte queue between the front end and the decode engine.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

   localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [1:0]  column_width;
      logic [15:0] running_width;
      logic        final_of_run;
      logic        final_of_string;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      CLS_ASCII,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_CONT,
      CLS_BAD
   } byte_class_type;

   // One queued byte together with its lead/continuation class.
   typedef struct packed {
      logic [7:0]     byte_value;
      logic           end_of_string;
      byte_class_type byte_class;
   } queue_entry_type;

   // One decoded code point on its way to the width stage.
   typedef struct packed {
      logic [20:0] code_point;
      logic        final_of_run;
      logic        final_of_string;
   } dec_result_type;

   localparam int NUM_ZERO = 15;
   localparam int NUM_WIDE = 13;

   localparam logic [20:0] ZERO_LO [NUM_ZERO] = '{
      21'h0300, 21'h0483, 21'h0591, 21'h0610, 21'h064B, 21'h0670, 21'h06D6,
      21'h0900, 21'h093A, 21'h0941, 21'h1AB0, 21'h1DC0, 21'h20D0, 21'hFE00,
      21'hFE20
   };
   localparam logic [20:0] ZERO_HI [NUM_ZERO] = '{
      21'h036F, 21'h0489, 21'h05BD, 21'h061A, 21'h065F, 21'h0670, 21'h06DC,
      21'h0903, 21'h093C, 21'h0948, 21'h1AFF, 21'h1DFF, 21'h20F0, 21'hFE0F,
      21'hFE2F
   };
   localparam logic [20:0] WIDE_LO [NUM_WIDE] = '{
      21'h1100, 21'h2E80, 21'h3041, 21'h3400, 21'h4E00, 21'hA000, 21'hAC00,
      21'hF900, 21'hFE30, 21'hFF00, 21'hFFE0, 21'h20000, 21'h30000
   };
   localparam logic [20:0] WIDE_HI [NUM_WIDE] = '{
      21'h115F, 21'h303E, 21'h33FF, 21'h4DBF, 21'h9FFF, 21'hA4CF, 21'hD7A3,
      21'hFAFF, 21'hFE6F, 21'hFF60, 21'hFFE6, 21'h2FFFD, 21'h3FFFD
   };

   // Terminal columns of a code point: controls and combining marks take
   // none, the wide ranges take two, everything else one.
   function automatic logic [1:0] cols_of(input logic [20:0] cp);
      logic zero_hit;
      logic wide_hit;
      zero_hit = (cp < 21'h20) || (cp >= 21'h7F && cp < 21'hA0);
      wide_hit = 1'b0;
      for (int i = 0; i < NUM_ZERO; i++) begin
         zero_hit = zero_hit || (cp >= ZERO_LO[i] && cp <= ZERO_HI[i]);
      end
      for (int i = 0; i < NUM_WIDE; i++) begin
         wide_hit = wide_hit || (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]);
      end
      if (zero_hit) begin
         return 2'd0;
      end else if (wide_hit) begin
         return 2'd2;
      end
      return 2'd1;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/utf8cw_front.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder front end
// Accepts input beats, classifies each byte and queues it for the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8cw_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire utf8cw_pkg::req_payload_type  req_payload,
   output logic                              deq_valid,
   input  wire logic                         deq_ready,
   output utf8cw_pkg::queue_entry_type       deq_entry
);
   import utf8cw_pkg::*;

   function automatic byte_class_type classify(input logic [7:0] b);
      priority if (b[7] == 1'b0) begin
         return CLS_ASCII;
      end else if (b[7:5] == 3'b110) begin
         return CLS_LEAD2;
      end else if (b[7:4] == 4'b1110) begin
         return CLS_LEAD3;
      end else if (b[7:3] == 5'b11110) begin
         return CLS_LEAD4;
      end else if (b[7:6] == 2'b10) begin
         return CLS_CONT;
      end else begin
         return CLS_BAD;
      end
   endfunction

   queue_entry_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     fill_ff, fill_in;
   logic                   push, pop;

   assign req_ready = (fill_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign deq_valid = (fill_ff != '0);
   assign deq_entry = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = deq_valid && deq_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{byte_value:    req_payload.byte_value,
                                  end_of_string: req_payload.end_of_string,
                                  byte_class:    classify(req_payload.byte_value)};
      end
   end

endmodule

`default_nettype wire

// ----- rtl/utf8cw_decode.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder sequence engine
// Holds bytes of an open sequence, decoding at most one code point per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8cw_decode (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          deq_valid,
   output logic                               deq_ready,
   input  wire utf8cw_pkg::queue_entry_type   deq_entry,
   output logic                               emit_valid,
   input  wire logic                          emit_ready,
   output utf8cw_pkg::dec_result_type         emit_result
);
   import utf8cw_pkg::*;

   typedef enum logic [1:0] {ST_FETCH, ST_RUN, ST_FLUSH} state_type;

   state_type        state_ff, state_in;
   logic [7:0]       byte_ff [PEND_DEPTH];
   logic [7:0]       byte_in [PEND_DEPTH];
   byte_class_type   cls_ff [PEND_DEPTH];
   byte_class_type   cls_in [PEND_DEPTH];
   logic [2:0]       cnt_ff, cnt_in;
   logic             eos_ff, eos_in;
   logic             hold_v_ff, hold_v_in;
   logic [20:0]      hold_cp_ff, hold_cp_in;

   logic [1:0]       extra;
   logic             bad_lead;
   logic             short_seq;
   logic             conts_ok;
   logic [20:0]      seq_cp;
   logic             has_res;
   logic             brk;
   logic [20:0]      res_cp;
   logic [2:0]       drop;
   logic [2:0]       next_cnt;
   logic             ends;
   logic [7:0]       shift_byte [PEND_DEPTH];
   byte_class_type   shift_cls [PEND_DEPTH];
   logic             advance;

   // One decode step on the held bytes.
   always_comb begin
      bad_lead = 1'b0;
      extra    = 2'd0;
      seq_cp   = {13'd0, byte_ff[0]};
      unique case (cls_ff[0])
         CLS_ASCII: begin
            extra  = 2'd0;
            seq_cp = {13'd0, byte_ff[0]};
         end
         CLS_LEAD2: begin
            extra  = 2'd1;
            seq_cp = {10'd0, byte_ff[0][4:0], byte_ff[1][5:0]};
         end
         CLS_LEAD3: begin
            extra  = 2'd2;
            seq_cp = {5'd0, byte_ff[0][3:0], byte_ff[1][5:0], byte_ff[2][5:0]};
         end
         CLS_LEAD4: begin
            extra  = 2'd3;
            seq_cp = {byte_ff[0][2:0], byte_ff[1][5:0], byte_ff[2][5:0],
                      byte_ff[3][5:0]};
         end
         default: begin
            bad_lead = 1'b1;
         end
      endcase

      short_seq = (cnt_ff < 3'(extra) + 3'd1);
      conts_ok  = (extra < 2'd1 || cls_ff[1] == CLS_CONT) &&
                  (extra < 2'd2 || cls_ff[2] == CLS_CONT) &&
                  (extra < 2'd3 || cls_ff[3] == CLS_CONT);

      has_res = 1'b1;
      brk     = 1'b0;
      res_cp  = REPLACEMENT_CP;
      drop    = 3'd1;
      if (bad_lead) begin
         drop = 3'd1;
      end else if (short_seq) begin
         // Incomplete: at end of string it collapses into one replacement.
         brk     = 1'b1;
         has_res = eos_ff;
         drop    = eos_ff ? cnt_ff : 3'd0;
      end else if (!conts_ok) begin
         drop = 3'd1;
      end else begin
         res_cp = seq_cp;
         drop   = 3'(extra) + 3'd1;
      end
      next_cnt = cnt_ff - drop;
      ends     = brk || (next_cnt == 3'd0);

      for (int i = 0; i < PEND_DEPTH; i++) begin
         shift_byte[i] = byte_ff[i];
         shift_cls[i]  = cls_ff[i];
      end
      unique case (drop)
         3'd1: begin
            for (int i = 0; i < PEND_DEPTH - 1; i++) begin
               shift_byte[i] = byte_ff[i+1];
               shift_cls[i]  = cls_ff[i+1];
            end
         end
         3'd2: begin
            for (int i = 0; i < PEND_DEPTH - 2; i++) begin
               shift_byte[i] = byte_ff[i+2];
               shift_cls[i]  = cls_ff[i+2];
            end
         end
         3'd3: begin
            shift_byte[0] = byte_ff[3];
            shift_cls[0]  = cls_ff[3];
         end
         default: begin
         end
      endcase
   end

   // Emission. A result is held until the next step shows whether it is the
   // last one caused by the current byte.
   always_comb begin
      emit_valid  = 1'b0;
      emit_result = '{code_point: hold_cp_ff, final_of_run: 1'b0,
                      final_of_string: 1'b0};
      advance     = 1'b1;
      unique case (state_ff)
         ST_RUN: begin
            if (has_res && hold_v_ff) begin
               emit_valid = 1'b1;
            end else if (has_res && ends) begin
               emit_valid  = 1'b1;
               emit_result = '{code_point: res_cp, final_of_run: 1'b1,
                               final_of_string: eos_ff};
            end else if (!has_res && hold_v_ff) begin
               emit_valid  = 1'b1;
               emit_result = '{code_point: hold_cp_ff, final_of_run: 1'b1,
                               final_of_string: eos_ff};
            end
            advance = !emit_valid || emit_ready;
         end
         ST_FLUSH: begin
            emit_valid  = 1'b1;
            emit_result = '{code_point: hold_cp_ff, final_of_run: 1'b1,
                            final_of_string: eos_ff};
            advance     = emit_ready;
         end
         default: begin
            advance = 1'b1;
         end
      endcase
   end

   assign deq_ready = (state_ff == ST_FETCH);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      eos_in     = eos_ff;
      hold_v_in  = hold_v_ff;
      hold_cp_in = hold_cp_ff;
      for (int i = 0; i < PEND_DEPTH; i++) begin
         byte_in[i] = byte_ff[i];
         cls_in[i]  = cls_ff[i];
      end
      unique case (state_ff)
         ST_FETCH: begin
            if (deq_valid) begin
               byte_in[cnt_ff[1:0]] = deq_entry.byte_value;
               cls_in[cnt_ff[1:0]]  = deq_entry.byte_class;
               cnt_in   = cnt_ff + 3'd1;
               eos_in   = deq_entry.end_of_string;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (advance) begin
               if (has_res) begin
                  for (int i = 0; i < PEND_DEPTH; i++) begin
                     byte_in[i] = shift_byte[i];
                     cls_in[i]  = shift_cls[i];
                  end
                  cnt_in = next_cnt;
                  if (ends && !hold_v_ff) begin
                     state_in = ST_FETCH;
                  end else begin
                     hold_v_in  = 1'b1;
                     hold_cp_in = res_cp;
                     state_in   = ends ? ST_FLUSH : ST_RUN;
                  end
               end else begin
                  hold_v_in = 1'b0;
                  state_in  = ST_FETCH;
               end
            end
         end
         ST_FLUSH: begin
            if (advance) begin
               hold_v_in = 1'b0;
               state_in  = ST_FETCH;
            end
         end
         default: begin
            state_in = ST_FETCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_FETCH;
         cnt_ff    <= '0;
         eos_ff    <= 1'b0;
         hold_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         eos_ff    <= eos_in;
         hold_v_ff <= hold_v_in;
      end
      hold_cp_ff <= hold_cp_in;
      for (int i = 0; i < PEND_DEPTH; i++) begin
         byte_ff[i] <= byte_in[i];
         cls_ff[i]  <= cls_in[i];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/utf8cw_width.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder width stage
// Looks up column width, keeps the saturating running total, drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8cw_width (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         emit_valid,
   output logic                              emit_ready,
   input  wire utf8cw_pkg::dec_result_type   emit_result,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output utf8cw_pkg::rsp_payload_type       rsp_payload
);
   import utf8cw_pkg::*;

   logic                 out_v_ff, out_v_in;
   rsp_payload_type      out_ff, out_in;
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic [1:0]           cols;
   logic [SUM_BITS:0]    sum_ext;
   logic [SUM_BITS-1:0]  sum_sat;
   logic                 take;

   assign emit_ready  = !out_v_ff || rsp_ready;
   assign take        = emit_valid && emit_ready;
   assign rsp_valid   = out_v_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      cols    = cols_of(emit_result.code_point);
      sum_ext = {1'b0, sum_ff} + (SUM_BITS+1)'(cols);
      sum_sat = sum_ext[SUM_BITS] ? SUM_MAX : sum_ext[SUM_BITS-1:0];

      out_in   = out_ff;
      out_v_in = out_v_ff && !rsp_ready;
      sum_in   = sum_ff;
      if (take) begin
         out_v_in = 1'b1;
         out_in   = '{code_point:      emit_result.code_point,
                      column_width:    cols,
                      running_width:   16'(sum_sat),
                      final_of_run:    emit_result.final_of_run,
                      final_of_string: emit_result.final_of_string};
         // The total starts over after the last result of a string.
         sum_in   = emit_result.final_of_string ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sum_ff   <= '0;
      end else begin
         out_v_ff <= out_v_in;
         sum_ff   <= sum_in;
      end
      out_ff <= out_in;
   end

endmodule

`default_nettype wire

// ----- rtl/utf8_decode_with_column_width.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder with terminal column width
// Byte-stream UTF-8 decoder emitting code points, widths and running widths.
// ----------------------------------------------------------------------------
// Bytes of a UTF-8 string enter on the req channel, one byte per beat, with
// end_of_string marking the final byte. Each rsp beat carries one decoded
// code point (U+FFFD for malformed input), its column width (0, 1 or 2) and
// the saturating total width of the string so far including this result;
// final_of_run flags the last result caused by an input byte and
// final_of_string the last result of a string, after which the total starts
// over. A byte that only extends an open sequence gives no result, and a byte
// that breaks a held sequence can replay the held bytes, so one byte may give
// up to four results. A byte is registered in the front queue, then the
// decode engine loads it in its fetch state and takes one decode step for
// each result or for a byte that completes nothing; when a result had to be
// held back to learn whether it was the last of its byte, the flush state
// drains it. A plain ASCII byte thus needs a fetch and one decode step; the
// engine's single decode step per cycle, when not stalled, sets the rate.
// The four-beat front queue takes bytes while the engine works, until full,
// and the result register holds one result while the consumer stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_decode_with_column_width (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire utf8cw_pkg::req_payload_type  req_payload,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output utf8cw_pkg::rsp_payload_type       rsp_payload
);
   import utf8cw_pkg::*;

   // Classified bytes waiting for the engine.
   queue_entry_type  deq_entry;
   logic             deq_valid;
   logic             deq_ready;

   // Decoded code points with their run and string flags.
   dec_result_type   emit_result;
   logic             emit_valid;
   logic             emit_ready;

   // Front end: takes beats and tags each byte as ASCII, lead, continuation
   // or invalid, so the engine never decodes a raw byte itself.
   utf8cw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .deq_valid   (deq_valid),
      .deq_ready   (deq_ready),
      .deq_entry   (deq_entry)
   );

   // Decode engine: holds the bytes of an open sequence, checks them once the
   // sequence is complete, and on a bad continuation consumes only the lead
   // so the remaining held bytes are decoded again.
   utf8cw_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .deq_valid   (deq_valid),
      .deq_ready   (deq_ready),
      .deq_entry   (deq_entry),
      .emit_valid  (emit_valid),
      .emit_ready  (emit_ready),
      .emit_result (emit_result)
   );

   // Width stage: range table lookup, saturating total and result register.
   utf8cw_width u_width (
      .clock       (clock),
      .reset       (reset),
      .emit_valid  (emit_valid),
      .emit_ready  (emit_ready),
      .emit_result (emit_result),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- rtl/utf8cw_checker.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder port checker
// Watches the result channel of the decoder and checks it over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_decode_with_column_width_assert.svh"

module utf8cw_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire utf8cw_pkg::rsp_payload_type  rsp_payload
);
   import utf8cw_pkg::*;

   logic [15:0]  prev_width_ff, prev_width_in;
   logic [16:0]  sum_next;
   logic [15:0]  expect_width;

   // Running width seen on the previous beat of the current string.
   always_comb begin
      prev_width_in = prev_width_ff;
      if (rsp_valid && rsp_ready) begin
         prev_width_in = rsp_payload.final_of_string ? 16'd0
                                                     : rsp_payload.running_width;
      end
      sum_next     = {1'b0, prev_width_ff} + 17'(rsp_payload.column_width);
      expect_width = sum_next[16] ? 16'hFFFF : sum_next[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_width_ff <= '0;
      end else begin
         prev_width_ff <= prev_width_in;
      end
   end

   `UCW_ASSERT_IMP(a_string_end_ends_run, rsp_valid && rsp_payload.final_of_string, rsp_payload.final_of_run, "last result of a string is not the last of its byte")
   `UCW_ASSERT_IMP(a_running_width, rsp_valid && (SUM_BITS == 16), rsp_payload.running_width == expect_width, "running width does not follow the column widths")
   `UCW_ASSERT_IMP(a_replacement_width, rsp_valid && rsp_payload.code_point == REPLACEMENT_CP, rsp_payload.column_width == 2'd1, "replacement character is not one column wide")
   `UCW_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result beat changed or was dropped")

endmodule

bind utf8_decode_with_column_width utf8cw_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
